>>> hw/rtl/ctxq_pkg.sv
// Package for the credit transmit queue: function, status, outcome, config-index
// and state codes, the slot descriptor type, the queue depth and other constants.
// No dependencies.
package ctxq_pkg;

    typedef enum logic [2:0] {
        FN_APPEND = 3'd0,
        FN_FREED  = 3'd1,
        FN_STATUS = 3'd2,
        FN_READ   = 3'd3,
        FN_DRAIN  = 3'd4,
        FN_STAT   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RES   = 2'd1,
        ST_CONN_LOST = 2'd2,
        ST_OTHER    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OC_OK        = 3'd0,
        OC_FULL_DROP = 3'd1,
        OC_NO_OFFER  = 3'd2,
        OC_NO_CONN   = 3'd3,
        OC_CONN_LOST = 3'd4,
        OC_RETRY_DROP = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_CONN   = 2'd0,
        CFG_CREDIT = 2'd1,
        CFG_RETRY  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    localparam int          QUEUE_DEPTH   = 16;
    localparam logic [15:0] NO_CONNECTION = 16'hFFFF;
    localparam int          STAT_COUNT    = 6;
    localparam int          STAT_QUEUED   = 0;
    localparam int          STAT_SENT     = 1;
    localparam int          STAT_DROPPED  = 2;
    localparam int          STAT_RETRIES  = 3;
    localparam int          STAT_RESOURCE = 4;
    localparam int          STAT_MAXDEPTH = 5;
    localparam logic [3:0]  RETRY_SAT     = 4'd15;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  channel;
        logic [7:0]  length;
    } meta_t;

endpackage

>>> hw/rtl/credit_tx_queue_with_retry.sv
// Credit transmit ring queue with retry: top level and only module.
// Depends on ctxq_pkg.
//
// Usage: one input beat carries one command (func) with its fields; each
// accepted beat yields exactly one result beat with the offer state, any
// read data, counts and an outcome code.
// Channels: in_valid/in_stall for commands, out_valid/out_stall for results.
// The plain write port (cfg_we, cfg_index, cfg_data) sets the connection
// handle, credit limit and retry limit; write it only while idle.
// Sequence: a command is accepted in the idle state and run in the execute
// state; the result beat is presented in the output state after it and
// leaves when out_stall is low. The next command is taken the cycle after
// the result beat leaves, so no new command is taken before the last
// result has left. The payload memory read in the accept cycle and the
// descriptor memory read at the new tail in the execute cycle set this order.
// Reset: queue empty, credits at the reset credit limit, statistics zero.
// Payload and descriptor memories are not cleared; reading a slot never
// written returns whatever is there.
// Stall: while out_stall is high the result beat holds and no new command
// is accepted.
module credit_tx_queue_with_retry #(
    parameter int MAX_PAYLOAD = 244
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    input  logic [15:0] char_handle,
    input  logic [7:0]  channel,
    input  logic [7:0]  freed_count,
    input  logic [1:0]  send_status,
    input  logic [3:0]  slot,
    input  logic [7:0]  index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        offer_valid,
    output logic [3:0]  offer_slot,
    output logic [15:0] offer_handle,
    output logic [7:0]  offer_channel,
    output logic [7:0]  offer_length,
    output logic [31:0] read_data,
    output logic [4:0]  pending_count,
    output logic [7:0]  credits_left,
    output logic [7:0]  drain_sent,
    output logic [2:0]  outcome,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int QUEUE_DEPTH = ctxq_pkg::QUEUE_DEPTH;
    localparam int TI_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PDEP  = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int PA_W  = $clog2(PDEP);
    localparam logic [FC_W-1:0] FULL_CNT = FC_W'(QUEUE_DEPTH);
    localparam logic [TI_W-1:0] LAST_IDX = TI_W'(QUEUE_DEPTH - 1);
    localparam logic [7:0]      MAXP     = 8'(MAX_PAYLOAD);

    // Configuration registers
    logic [15:0] conn_reg;
    logic [7:0]  climit_reg;
    logic [3:0]  rlimit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg   <= ctxq_pkg::NO_CONNECTION;
            climit_reg <= 8'd4;
            rlimit_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctxq_pkg::CFG_CONN:   conn_reg   <= cfg_data;
                ctxq_pkg::CFG_CREDIT: climit_reg <= cfg_data[7:0];
                ctxq_pkg::CFG_RETRY:  rlimit_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Control flow
    ctxq_pkg::state_t state_reg, state_next;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ctxq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctxq_pkg::S_IDLE: if (in_valid) state_next = ctxq_pkg::S_EXEC;
            ctxq_pkg::S_EXEC: state_next = ctxq_pkg::S_OUT;
            ctxq_pkg::S_OUT:  if (!out_stall) state_next = ctxq_pkg::S_IDLE;
            default:          state_next = ctxq_pkg::S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != ctxq_pkg::S_IDLE);
    assign out_valid = (state_reg == ctxq_pkg::S_OUT);
    assign accept    = in_valid && !in_stall;

    // Hold the command for the execute cycle
    logic [2:0]  func_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] handle_reg;
    logic [7:0]  chan_reg;
    logic [7:0]  freed_reg;
    logic [1:0]  status_reg;
    logic [7:0]  idx_reg;
    logic        rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            byte_reg   <= payload_byte;
            last_reg   <= last_byte;
            handle_reg <= char_handle;
            chan_reg   <= channel;
            freed_reg  <= freed_count;
            status_reg <= send_status;
            idx_reg    <= index;
            rd_ok_reg  <= (32'(slot) < 32'(QUEUE_DEPTH)) && (index < MAXP);
        end
    end

    // Payload memory: read in the accept cycle, written in the execute cycle
    logic [7:0]      pay_mem [PDEP];
    logic [7:0]      pay_rdata_reg;
    logic [PA_W-1:0] pay_raddr;
    logic [PA_W-1:0] pay_waddr;
    logic            pay_we;

    assign pay_raddr = PA_W'(32'(slot) * MAX_PAYLOAD + 32'(index));

    // Descriptor memory: written at the head on commit, read at the new tail
    ctxq_pkg::meta_t meta_mem [QUEUE_DEPTH];
    ctxq_pkg::meta_t meta_wdata;
    ctxq_pkg::meta_t meta_rdata_reg;
    logic            meta_we;

    // Queue state
    logic [TI_W-1:0] head_reg, head_next;
    logic [TI_W-1:0] tail_reg, tail_next;
    logic [FC_W-1:0] count_reg, count_next;
    logic [7:0]      fill_reg, fill_next;
    logic [7:0]      credit_reg, credit_next;
    logic            offer_reg, offer_next;
    logic [7:0]      sent_reg, sent_next;
    logic [3:0]      retries_reg [QUEUE_DEPTH];
    logic [31:0]     stat_reg [ctxq_pkg::STAT_COUNT];
    logic [31:0]     rdata_reg, rdata_next;
    logic [2:0]      oc_reg, oc_next;

    logic            exec;
    logic            ret_we;
    logic [TI_W-1:0] ret_addr;
    logic [3:0]      ret_wdata;
    logic [ctxq_pkg::STAT_COUNT-1:0] stat_inc;
    logic            maxd_we;
    logic [3:0]      ret_bump;
    logic [7:0]      fill_after;
    logic [8:0]      credit_sum;
    logic            drain_go;

    assign exec       = (state_reg == ctxq_pkg::S_EXEC);

    // Write only in the execute cycle; the command registers hold afterwards
    always_ff @(posedge clk)
    begin
        if (exec && pay_we)
            pay_mem[pay_waddr] <= byte_reg;
        if (accept)
            pay_rdata_reg <= pay_mem[pay_raddr];
    end

    assign pay_waddr  = PA_W'(32'(head_reg) * MAX_PAYLOAD + 32'(fill_reg));
    assign meta_wdata = '{handle: handle_reg, channel: chan_reg, length: fill_after};
    assign ret_bump   = (retries_reg[tail_reg] < ctxq_pkg::RETRY_SAT)
                        ? retries_reg[tail_reg] + 4'd1 : retries_reg[tail_reg];
    assign fill_after = (fill_reg < MAXP) ? fill_reg + 8'd1 : fill_reg;
    assign credit_sum = {1'b0, credit_reg} + {1'b0, freed_reg};

    function automatic logic [TI_W-1:0] step_idx(input logic [TI_W-1:0] s);
        step_idx = (s == LAST_IDX) ? '0 : s + 1'b1;
    endfunction

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        credit_next = credit_reg;
        offer_next  = offer_reg;
        sent_next   = sent_reg;
        rdata_next  = '0;
        oc_next     = ctxq_pkg::OC_OK;
        pay_we      = 1'b0;
        meta_we     = 1'b0;
        ret_we      = 1'b0;
        ret_addr    = tail_reg;
        ret_wdata   = '0;
        stat_inc    = '0;
        maxd_we     = 1'b0;
        drain_go    = 1'b0;

        case (func_reg)
            ctxq_pkg::FN_APPEND:
            begin
                if (count_reg == FULL_CNT)
                begin
                    if (last_reg)
                    begin
                        stat_inc[ctxq_pkg::STAT_DROPPED] = 1'b1;
                        fill_next = '0;
                        oc_next   = ctxq_pkg::OC_FULL_DROP;
                    end
                end
                else
                begin
                    pay_we    = (fill_reg < MAXP);
                    fill_next = fill_after;
                    if (last_reg)
                    begin
                        meta_we    = 1'b1;
                        ret_we     = 1'b1;
                        ret_addr   = head_reg;
                        head_next  = step_idx(head_reg);
                        count_next = count_reg + 1'b1;
                        fill_next  = '0;
                        stat_inc[ctxq_pkg::STAT_QUEUED] = 1'b1;
                        maxd_we = (32'(count_next) > stat_reg[ctxq_pkg::STAT_MAXDEPTH]);
                    end
                end
            end
            ctxq_pkg::FN_FREED:
            begin
                credit_next = (credit_sum > {1'b0, climit_reg}) ? climit_reg
                                                                 : credit_sum[7:0];
                drain_go = 1'b1;
            end
            ctxq_pkg::FN_STATUS:
            begin
                if (!offer_reg)
                    oc_next = ctxq_pkg::OC_NO_OFFER;
                else
                begin
                    case (status_reg)
                        ctxq_pkg::ST_OK:
                        begin
                            ret_we      = 1'b1;
                            tail_next   = step_idx(tail_reg);
                            count_next  = count_reg - 1'b1;
                            credit_next = (credit_reg != 8'd0) ? credit_reg - 8'd1 : credit_reg;
                            sent_next   = (sent_reg != 8'hFF) ? sent_reg + 8'd1 : sent_reg;
                            stat_inc[ctxq_pkg::STAT_SENT] = 1'b1;
                            offer_next  = (count_next != '0) && (credit_next != 8'd0);
                        end
                        ctxq_pkg::ST_NO_RES:
                        begin
                            stat_inc[ctxq_pkg::STAT_RESOURCE] = 1'b1;
                            credit_next = '0;
                            offer_next  = 1'b0;
                        end
                        ctxq_pkg::ST_CONN_LOST:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            count_next  = '0;
                            fill_next   = '0;
                            credit_next = climit_reg;
                            offer_next  = 1'b0;
                            oc_next     = ctxq_pkg::OC_CONN_LOST;
                        end
                        default:
                        begin
                            stat_inc[ctxq_pkg::STAT_RETRIES] = 1'b1;
                            ret_we = 1'b1;
                            if (ret_bump >= rlimit_reg)
                            begin
                                tail_next  = step_idx(tail_reg);
                                count_next = count_reg - 1'b1;
                                stat_inc[ctxq_pkg::STAT_DROPPED] = 1'b1;
                                oc_next    = ctxq_pkg::OC_RETRY_DROP;
                                offer_next = (count_next != '0) && (credit_reg != 8'd0);
                            end
                            else
                            begin
                                ret_wdata  = ret_bump;
                                offer_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ctxq_pkg::FN_READ:
            begin
                if (rd_ok_reg)
                    rdata_next = {24'd0, pay_rdata_reg};
            end
            ctxq_pkg::FN_DRAIN:
                drain_go = 1'b1;
            ctxq_pkg::FN_STAT:
            begin
                if (idx_reg < 8'(ctxq_pkg::STAT_COUNT))
                    rdata_next = stat_reg[idx_reg[2:0]];
            end
            default: ;
        endcase

        // Begin a drain: needs frames and a connection; an open offer stands
        if (drain_go && count_reg != '0)
        begin
            if (conn_reg == ctxq_pkg::NO_CONNECTION)
                oc_next = ctxq_pkg::OC_NO_CONN;
            else if (!offer_reg)
            begin
                sent_next  = '0;
                offer_next = (credit_next != 8'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && meta_we)
            meta_mem[head_reg] <= meta_wdata;
        // Read the new tail; forward a descriptor written in the same cycle
        if (exec)
        begin
            if (meta_we && head_reg == tail_next)
                meta_rdata_reg <= meta_wdata;
            else
                meta_rdata_reg <= meta_mem[tail_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            fill_reg   <= '0;
            credit_reg <= 8'd4;
            offer_reg  <= 1'b0;
            sent_reg   <= '0;
            rdata_reg  <= '0;
            oc_reg     <= ctxq_pkg::OC_OK;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                retries_reg[i] <= '0;
            for (int i = 0; i < ctxq_pkg::STAT_COUNT; i++)
                stat_reg[i] <= '0;
        end
        else if (exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
            offer_reg  <= offer_next;
            sent_reg   <= sent_next;
            rdata_reg  <= rdata_next;
            oc_reg     <= oc_next;
            if (oc_next == ctxq_pkg::OC_CONN_LOST)
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    retries_reg[i] <= '0;
            end
            else if (ret_we)
                retries_reg[ret_addr] <= ret_wdata;
            for (int i = 0; i < ctxq_pkg::STAT_COUNT; i++)
            begin
                if (stat_inc[i])
                    stat_reg[i] <= stat_reg[i] + 32'd1;
            end
            if (maxd_we)
                stat_reg[ctxq_pkg::STAT_MAXDEPTH] <= 32'(count_next);
        end
    end

    // Result beat
    assign offer_valid   = offer_reg;
    assign offer_slot    = offer_reg ? 4'(tail_reg) : 4'd0;
    assign offer_handle  = offer_reg ? meta_rdata_reg.handle : 16'd0;
    assign offer_channel = offer_reg ? meta_rdata_reg.channel : 8'd0;
    assign offer_length  = offer_reg ? meta_rdata_reg.length : 8'd0;
    assign read_data     = rdata_reg;
    assign pending_count = 5'(count_reg);
    assign credits_left  = credit_reg;
    assign drain_sent    = sent_reg;
    assign outcome       = oc_reg;

    // An offer never stands without credits or frames
    a_offer_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && offer_valid |-> credits_left != 8'd0 && pending_count != 5'd0)
        else $error("offer without credits or frames");

    // Connection loss empties the queue
    a_conn_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == ctxq_pkg::OC_CONN_LOST |-> pending_count == 5'd0
        && !offer_valid)
        else $error("queue not cleared on connection loss");

    // Every accepted command gives a result beat once its execute state has passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("result missing");

    // Credits stay within the limit after a freed-credit command
    a_credit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        exec && func_reg == ctxq_pkg::FN_FREED |=> credit_reg <= climit_reg)
        else $error("credits above limit");

endmodule
